[rtl/tgpe_pkg.sv]
`timescale 1ns / 1ps
package tgpe_pkg;

  localparam int MAX_CLICKS = 15;
  localparam int CNT_W = $clog2(MAX_CLICKS + 1);

  localparam logic [1:0] MODE_BEGIN  = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [2:0] G_ONE_TAP    = 3'd0;
  localparam logic [2:0] G_TWO_TAP    = 3'd1;
  localparam logic [2:0] G_THREE_TAP  = 3'd2;
  localparam logic [2:0] G_DRAG       = 3'd3;
  localparam logic [2:0] G_LONG_PRESS = 3'd4;
  localparam logic [2:0] G_TWO_DRAG   = 3'd5;
  localparam logic [2:0] G_PINCH      = 3'd6;
  localparam logic [2:0] G_UNUSED     = 3'd7;

  localparam logic [2:0] K_MOTION    = 3'd0;
  localparam logic [2:0] K_PRESS     = 3'd1;
  localparam logic [2:0] K_RELEASE   = 3'd2;
  localparam logic [2:0] K_CTRL_DOWN = 3'd3;
  localparam logic [2:0] K_CTRL_UP   = 3'd4;

  localparam logic [2:0] BTN_NONE  = 3'd0;
  localparam logic [2:0] BTN_LEFT  = 3'd1;
  localparam logic [2:0] BTN_MID   = 3'd2;
  localparam logic [2:0] BTN_RIGHT = 3'd3;
  localparam logic [2:0] BTN_UP    = 3'd4;
  localparam logic [2:0] BTN_DOWN  = 3'd5;
  localparam logic [2:0] BTN_LEFTW = 3'd6;
  localparam logic [2:0] BTN_RIGHTW = 3'd7;

  localparam logic [1:0] CFG_SCROLL_STEP = 2'd0;
  localparam logic [1:0] CFG_ZOOM_STEP   = 2'd1;
  localparam logic [1:0] CFG_TAP_TIMEOUT = 2'd2;
  localparam logic [1:0] CFG_TAP_RADIUS  = 2'd3;

  localparam logic [9:0]  SCROLL_STEP_RST = 10'd50;
  localparam logic [9:0]  ZOOM_STEP_RST   = 10'd30;
  localparam logic [15:0] TAP_TIMEOUT_RST = 16'd1000;
  localparam logic [9:0]  TAP_RADIUS_RST  = 10'd50;

  typedef struct packed {
    logic [1:0]         mode;
    logic [2:0]         gesture;
    logic [15:0]        pos_x;
    logic [15:0]        pos_y;
    logic signed [15:0] magnitude_x;
    logic signed [15:0] magnitude_y;
    logic [31:0]        now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  button;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       tap_mul;
    logic       tap_cmp;
    logic       sqrt_init;
    logic       ref_drag;
    logic       ref_pinch;
    logic       emit;
    logic [2:0] emit_kind;
    logic [2:0] emit_btn;
    logic       q_axis_x;
    logic       q_pinch;
    logic       q_move_up;
    logic       q_move_dn;
    logic       flush;
  } tgpe_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] gesture;
    logic       push_ok;
    logic       flush_ok;
    logic       sqrt_done;
    logic       q_up;
    logic       q_dn;
  } tgpe_sts_t;

  function automatic logic [2:0] tap_button(input logic [2:0] g);
    case (g)
      G_ONE_TAP: tap_button = BTN_LEFT;
      G_TWO_TAP: tap_button = BTN_RIGHT;
      default:   tap_button = BTN_MID;
    endcase
  endfunction

endpackage

[rtl/tgpe_ctrl.sv]
`timescale 1ns / 1ps
module tgpe_ctrl import tgpe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  tgpe_sts_t sts,
  output logic      idle,
  output tgpe_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_TAP_MUL, S_TAP_CMP, S_SQRT, S_MOT, S_BTN1, S_BTN2,
    S_CTRL_DN, S_Q_CHK, S_Q_PRESS, S_Q_REL, S_CTRL_UP, S_FLUSH
  } state_t;

  state_t           state_r, state_nxt;
  logic             axis_x_r, axis_x_nxt;
  logic             dn_r, dn_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic is_tap, is_hold, is_pinch, cnt_ok;
  logic [2:0] hold_btn, up_btn, dn_btn;

  always_comb begin
    is_tap   = (sts.gesture == G_ONE_TAP) || (sts.gesture == G_TWO_TAP) ||
               (sts.gesture == G_THREE_TAP);
    is_hold  = (sts.gesture == G_DRAG) || (sts.gesture == G_LONG_PRESS);
    is_pinch = (sts.gesture == G_PINCH);
    hold_btn = (sts.gesture == G_DRAG) ? BTN_LEFT : BTN_RIGHT;
    cnt_ok   = (cnt_r != CNT_W'(MAX_CLICKS));
    up_btn   = (axis_x_r && !is_pinch) ? BTN_LEFTW : BTN_UP;
    dn_btn   = (axis_x_r && !is_pinch) ? BTN_RIGHTW : BTN_DOWN;
  end

  always_comb begin
    state_nxt  = state_r;
    axis_x_nxt = axis_x_r;
    dn_nxt     = dn_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    cmd.q_axis_x = axis_x_r;
    cmd.q_pinch  = is_pinch;
    idle       = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        axis_x_nxt = is_pinch;
        dn_nxt     = 1'b0;
        cnt_nxt    = '0;
        if (sts.mode == MODE_BEGIN && is_tap) begin
          state_nxt = S_TAP_MUL;
        end else if (is_pinch && (sts.mode == MODE_BEGIN || sts.mode == MODE_UPDATE)) begin
          cmd.sqrt_init = 1'b1;
          state_nxt     = S_SQRT;
        end else if (sts.mode == MODE_BEGIN && sts.gesture == G_TWO_DRAG) begin
          cmd.ref_drag = 1'b1;
          state_nxt    = S_MOT;
        end else if (is_hold && sts.mode != MODE_UNUSED) begin
          state_nxt = S_MOT;
        end else if (sts.mode == MODE_UPDATE && sts.gesture == G_TWO_DRAG) begin
          state_nxt = S_MOT;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_TAP_MUL: begin
        cmd.tap_mul = 1'b1;
        state_nxt   = S_TAP_CMP;
      end
      S_TAP_CMP: begin
        cmd.tap_cmp = 1'b1;
        state_nxt   = S_MOT;
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.ref_pinch = (sts.mode == MODE_BEGIN);
          state_nxt     = S_MOT;
        end
      end
      S_MOT: begin
        if (sts.push_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_MOTION;
          cmd.emit_btn  = BTN_NONE;
          if (sts.mode == MODE_BEGIN && (is_tap || is_hold)) begin
            state_nxt = S_BTN1;
          end else if (sts.mode == MODE_END && is_hold) begin
            state_nxt = S_BTN1;
          end else if (sts.mode == MODE_UPDATE && sts.gesture == G_TWO_DRAG) begin
            state_nxt = S_Q_CHK;
          end else if (sts.mode == MODE_UPDATE && is_pinch && (sts.q_up || sts.q_dn)) begin
            state_nxt = S_CTRL_DN;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_BTN1: begin
        if (sts.push_ok) begin
          cmd.emit = 1'b1;
          if (is_tap) begin
            cmd.emit_kind = K_PRESS;
            cmd.emit_btn  = tap_button(sts.gesture);
            state_nxt     = S_BTN2;
          end else begin
            cmd.emit_kind = (sts.mode == MODE_END) ? K_RELEASE : K_PRESS;
            cmd.emit_btn  = hold_btn;
            state_nxt     = S_FLUSH;
          end
        end
      end
      S_BTN2: begin
        if (sts.push_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_RELEASE;
          cmd.emit_btn  = tap_button(sts.gesture);
          state_nxt     = S_FLUSH;
        end
      end
      S_CTRL_DN: begin
        if (sts.push_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_CTRL_DOWN;
          cmd.emit_btn  = BTN_NONE;
          state_nxt     = S_Q_CHK;
        end
      end
      S_Q_CHK: begin
        if (!dn_r) begin
          if (cnt_ok && sts.q_up) begin
            state_nxt = S_Q_PRESS;
          end else begin
            dn_nxt  = 1'b1;
            cnt_nxt = '0;
          end
        end else if (cnt_ok && sts.q_dn) begin
          state_nxt = S_Q_PRESS;
        end else begin
          // One axis is done: a two-finger drag goes from vertical to horizontal scroll; a pinch ends with control up.
          dn_nxt  = 1'b0;
          cnt_nxt = '0;
          if (is_pinch) begin
            state_nxt = S_CTRL_UP;
          end else if (!axis_x_r) begin
            axis_x_nxt = 1'b1;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_Q_PRESS: begin
        if (sts.push_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_PRESS;
          cmd.emit_btn  = dn_r ? dn_btn : up_btn;
          state_nxt     = S_Q_REL;
        end
      end
      S_Q_REL: begin
        if (sts.push_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_RELEASE;
          cmd.emit_btn  = dn_r ? dn_btn : up_btn;
          cmd.q_move_up = !dn_r;
          cmd.q_move_dn = dn_r;
          cnt_nxt       = cnt_r + CNT_W'(1);
          state_nxt     = S_Q_CHK;
        end
      end
      S_CTRL_UP: begin
        if (sts.push_ok) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = K_CTRL_UP;
          cmd.emit_btn  = BTN_NONE;
          state_nxt     = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (sts.flush_ok) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      axis_x_r <= 1'b0;
      dn_r     <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      axis_x_r <= axis_x_nxt;
      dn_r     <= dn_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/tgpe_dp.sv]
`timescale 1ns / 1ps
module tgpe_dp import tgpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  tgpe_cmd_t   cmd,
  output tgpe_sts_t   sts,
  input  logic        out_stall,
  output logic        out_valid,
  output out_item_t   out_data
);

  in_item_t in_r;
  logic [9:0]  scroll_step_r, zoom_step_r, tap_radius_r;
  logic [15:0] tap_timeout_r;

  logic signed [17:0] ref_x_r, ref_y_r;
  logic [15:0] first_x_r, first_y_r, ox_r, oy_r;
  logic        tap_seen_r;
  logic [31:0] last_ms_r;

  logic [33:0] dx2_r, dy2_r;
  logic [19:0] r2_r;
  logic        win_r;

  logic [31:0] sq_rem_r, sq_root_r;
  logic [3:0]  sq_cnt_r;
  logic        sq_run_r;

  logic       pend_v_r;
  logic [2:0] pend_kind_r, pend_btn_r;
  logic       out_valid_r;
  out_item_t  out_r;

  // Tap distance terms.
  logic signed [16:0] dx, dy;
  logic signed [33:0] dx_sq, dy_sq;
  logic [15:0] ax, ay;
  logic [31:0] mag_sq;
  logic [34:0] d2;
  logic [31:0] elapsed;

  // Square root step.
  logic [31:0] sq_bit, sq_trial;

  // Quantizer.
  logic [9:0]         step;
  logic signed [17:0] target, refv;
  logic signed [18:0] diff, pos_s, neg_s;

  logic out_free, push_ok;

  always_comb begin
    dx      = $signed({1'b0, first_x_r}) - $signed({1'b0, in_r.pos_x});
    dy      = $signed({1'b0, first_y_r}) - $signed({1'b0, in_r.pos_y});
    dx_sq   = dx * dx;
    dy_sq   = dy * dy;
    ax      = in_r.magnitude_x[15] ? 16'(-in_r.magnitude_x) : in_r.magnitude_x;
    ay      = in_r.magnitude_y[15] ? 16'(-in_r.magnitude_y) : in_r.magnitude_y;
    mag_sq  = ax * ax + ay * ay;
    d2      = {1'b0, dx2_r} + {1'b0, dy2_r};
    elapsed = in_r.now_ms - last_ms_r;

    sq_bit   = 32'h4000_0000 >> {sq_cnt_r, 1'b0};
    sq_trial = sq_root_r + sq_bit;

    step = cmd.q_pinch ? zoom_step_r : scroll_step_r;
    if (step == 10'd0) begin
      step = 10'd1;
    end
    if (!cmd.q_axis_x) begin
      target = 18'(in_r.magnitude_y);
    end else if (cmd.q_pinch) begin
      target = $signed({1'b0, sq_root_r[16:0]});
    end else begin
      target = 18'(in_r.magnitude_x);
    end
    refv  = cmd.q_axis_x ? ref_x_r : ref_y_r;
    diff  = 19'(target) - 19'(refv);
    pos_s = $signed({9'd0, step});
    neg_s = -pos_s;

    out_free = !out_valid_r || !out_stall;
    push_ok  = !pend_v_r || out_free;

    sts.mode      = in_r.mode;
    sts.gesture   = in_r.gesture;
    sts.push_ok   = push_ok;
    sts.flush_ok  = push_ok;
    sts.sqrt_done = !sq_run_r;
    sts.q_up      = diff > pos_s;
    sts.q_dn      = diff < neg_s;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
      ox_r <= in_data.pos_x;
      oy_r <= in_data.pos_y;
    end
    if (cmd.tap_mul) begin
      dx2_r <= dx_sq;
      dy2_r <= dy_sq;
      r2_r  <= tap_radius_r * tap_radius_r;
    end
    if (cmd.tap_cmp && win_r && (d2 < {15'd0, r2_r})) begin
      ox_r <= first_x_r;
      oy_r <= first_y_r;
    end
    if (cmd.sqrt_init) begin
      sq_rem_r  <= mag_sq;
      sq_root_r <= '0;
    end else if (sq_run_r) begin
      if (sq_rem_r >= sq_trial) begin
        sq_rem_r  <= sq_rem_r - sq_trial;
        sq_root_r <= (sq_root_r >> 1) + sq_bit;
      end else begin
        sq_root_r <= sq_root_r >> 1;
      end
    end
    if (cmd.emit) begin
      pend_kind_r <= cmd.emit_kind;
      pend_btn_r  <= cmd.emit_btn;
    end
    if ((cmd.emit || cmd.flush) && pend_v_r) begin
      out_r.kind   <= pend_kind_r;
      out_r.button <= pend_btn_r;
      out_r.out_x  <= ox_r;
      out_r.out_y  <= oy_r;
      out_r.last   <= cmd.flush;
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scroll_step_r <= SCROLL_STEP_RST;
      zoom_step_r   <= ZOOM_STEP_RST;
      tap_timeout_r <= TAP_TIMEOUT_RST;
      tap_radius_r  <= TAP_RADIUS_RST;
      ref_x_r       <= '0;
      ref_y_r       <= '0;
      first_x_r     <= '0;
      first_y_r     <= '0;
      tap_seen_r    <= 1'b0;
      last_ms_r     <= '0;
      win_r         <= 1'b0;
      sq_run_r      <= 1'b0;
      sq_cnt_r      <= '0;
      pend_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SCROLL_STEP: scroll_step_r <= cfg_data[9:0];
          CFG_ZOOM_STEP:   zoom_step_r   <= cfg_data[9:0];
          CFG_TAP_TIMEOUT: tap_timeout_r <= cfg_data;
          CFG_TAP_RADIUS:  tap_radius_r  <= cfg_data[9:0];
          default: ;
        endcase
      end
      if (cmd.tap_mul) begin
        win_r <= tap_seen_r && (elapsed < {16'd0, tap_timeout_r});
      end
      if (cmd.tap_cmp) begin
        // A tap that does not snap becomes the new first tap.
        if (!(win_r && (d2 < {15'd0, r2_r}))) begin
          first_x_r <= in_r.pos_x;
          first_y_r <= in_r.pos_y;
        end
        tap_seen_r <= 1'b1;
        last_ms_r  <= in_r.now_ms;
      end
      if (cmd.sqrt_init) begin
        sq_run_r <= 1'b1;
        sq_cnt_r <= '0;
      end else if (sq_run_r) begin
        sq_cnt_r <= sq_cnt_r + 4'd1;
        if (sq_cnt_r == 4'd15) begin
          sq_run_r <= 1'b0;
        end
      end
      if (cmd.ref_drag) begin
        ref_x_r <= 18'(in_r.magnitude_x);
        ref_y_r <= 18'(in_r.magnitude_y);
      end
      if (cmd.ref_pinch) begin
        ref_x_r <= $signed({1'b0, sq_root_r[16:0]});
      end
      if (cmd.q_move_up || cmd.q_move_dn) begin
        if (cmd.q_axis_x) begin
          ref_x_r <= cmd.q_move_up ? ref_x_r + $signed({8'd0, step})
                                   : ref_x_r - $signed({8'd0, step});
        end else begin
          ref_y_r <= cmd.q_move_up ? ref_y_r + $signed({8'd0, step})
                                   : ref_y_r - $signed({8'd0, step});
        end
      end
      // The newest result waits in the pending slot until the next one shows
      // whether it is the last of its burst.
      if (cmd.emit) begin
        pend_v_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_v_r <= 1'b0;
      end
      if ((cmd.emit || cmd.flush) && pend_v_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

[rtl/touch_gesture_to_pointer_events.sv]
`timescale 1ns / 1ps
// Turns touch gesture events into mouse-style events, one result per cycle
// at best. The input is stalled while an item is at work, so a new item is
// taken only once the last one is through. A pinch begin or update waits for
// the square root, 16 steps at one bit pair per cycle; a pinch update that
// zooms then adds a control press, a press and release per zoom click and a
// control release. A two-finger drag update adds a press and release per
// scroll click on each axis, up to the click cap. Stalls on the result side
// hold the block back. The configuration port is always ready.
module touch_gesture_to_pointer_events import tgpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tgpe_cmd_t cmd;
  tgpe_sts_t sts;
  logic      idle;

  assign in_stall  = !idle;
  assign cfg_ready = 1'b1;

  tgpe_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_valid && idle),
    .sts     (sts),
    .idle    (idle),
    .cmd     (cmd)
  );

  tgpe_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[rtl/tgpe_checker.sv]
`timescale 1ns / 1ps
module tgpe_checker import tgpe_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A result held under stall keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An accepted item keeps the input closed on the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  // Once the input reopens, any waiting result closes its burst.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !in_stall |-> out_data.last)
    else $error("burst not closed when input reopened");

  // Reset leaves no result on the output.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind touch_gesture_to_pointer_events tgpe_checker u_tgpe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
